// ===== rtl/cfrp_pkg.sv =====
// Package with the transaction types and fixed constants of the CSI feedback record parser.
package cfrp_pkg;

    localparam int unsigned HDR_LEN         = 20;
    localparam int unsigned MAX_PUSH        = 3;
    localparam int unsigned OUT_FIFO_DEPTH  = 8;
    localparam int unsigned OUT_FIFO_ACCEPT = 4;
    localparam int unsigned OUT_PTR_W       = $clog2(OUT_FIFO_DEPTH);
    localparam int unsigned OUT_LVL_W       = $clog2(OUT_FIFO_DEPTH + 1);

    localparam int unsigned HDR_NRX  = 8;
    localparam int unsigned HDR_NTX  = 9;
    localparam int unsigned HDR_PROD = 10;

    typedef enum logic [1:0] {
        KIND_CSI     = 2'd0,
        KIND_TIMING  = 2'd1,
        KIND_RADIO   = 2'd2,
        KIND_ANTENNA = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } in_t;

    typedef struct packed {
        kind_t             kind;
        logic signed [7:0] real_part;
        logic signed [7:0] imag_part;
        logic [1:0]        tx_antenna;
        logic [1:0]        rx_antenna;
        logic [4:0]        subcarrier;
        logic [55:0]       info;
        logic              last_of_run;
        logic              record_done;
    } out_t;

    typedef struct packed {
        logic [1:0]              count;
        out_t [MAX_PUSH-1:0]     item;
    } push_t;

endpackage

// ===== rtl/cfrp_result_fifo.sv =====
// Result queue that takes up to three results per cycle and delivers one per cycle while m_ready is high.
module cfrp_result_fifo
    import cfrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  push_t                push,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    output logic [OUT_LVL_W-1:0] level
);

    out_t                 mem_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_LVL_W-1:0] count_reg;
    logic [OUT_LVL_W-1:0] count_next;
    logic                 pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign level   = count_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push.count);
        count_next  = count_reg + OUT_LVL_W'(push.count) - OUT_LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (2'(i) < push.count) begin
                mem_reg[wr_ptr_reg + OUT_PTR_W'(i)] <= push.item[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
        end
    end

endmodule

// ===== rtl/csi_feedback_record_parser_core.sv =====
// Top level of the CSI feedback record parser: header capture, payload unpacking, result queue.
//
// The s_ channel takes one record byte per transaction, with end_of_record set on the
// last byte of a record; the next byte starts a new record. The m_ channel delivers
// result transactions: three header results after header byte 19, then one CSI
// element for each payload byte that completes an element's sixteen bits.
// A byte is registered at acceptance and parsed in the following cycle, and its
// results enter an eight-entry queue that drives the m_ channel directly, so the
// first result of a byte reaches m_data through the input register and then the queue registers.
// s_ready stays high while the queue holds four results or fewer, so a byte is taken
// every cycle as long as the receiver keeps up; the three header results add a backlog
// of two results, which drains while payload bytes continue to flow.
// When the receiver stalls, results accumulate in the queue and s_ready falls
// once more than four are waiting; nothing is dropped.
// A synchronous active-low reset empties the queue and returns the parser to the
// start of a record. Stored header bytes are not cleared.
module csi_feedback_record_parser_core
    import cfrp_pkg::*;
#(
    parameter int unsigned MAX_ANT         = 3,
    parameter int unsigned NUM_SUBCARRIERS = 30
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int unsigned ANT_W = (MAX_ANT > 1) ? $clog2(MAX_ANT) : 1;
    localparam int unsigned SC_W  = (NUM_SUBCARRIERS > 1) ? $clog2(NUM_SUBCARRIERS) : 1;
    localparam logic [SC_W:0] SC_COUNT = (SC_W+1)'(NUM_SUBCARRIERS);
    localparam logic [7:0]    ANT_MAX  = 8'(MAX_ANT);

    logic                 in_valid_reg;
    in_t                  in_reg;
    logic [7:0]           header_reg [HDR_LEN];
    logic [7:0]           hdr_view   [HDR_LEN];
    logic [15:0]          pos_reg;
    logic [15:0]          pos_next;
    logic [23:0]          win_reg;
    logic [23:0]          win_next;
    logic [15:0]          neb_reg;
    logic [15:0]          neb_next;
    logic [SC_W-1:0]      sub_reg;
    logic [SC_W-1:0]      sub_next;
    logic [ANT_W-1:0]     tx_reg;
    logic [ANT_W-1:0]     tx_next;
    logic [ANT_W-1:0]     rx_reg;
    logic [ANT_W-1:0]     rx_next;
    logic                 fin_reg;
    logic                 fin_next;
    logic [15:0]          prod_reg;
    logic                 ant_ok_reg;
    logic [OUT_LVL_W-1:0] level;
    push_t                push;

    logic                 in_header;
    logic [15:0]          pay_pos;
    logic [16:0]          end_byte;
    logic                 emit;
    logic [4:0]           off;
    logic [ANT_W:0]       rx_inc;
    logic [ANT_W:0]       tx_inc;
    logic [SC_W:0]        sub_inc;
    logic [31:0]          calc_sum;
    logic [15:0]          len;
    logic                 len_ok;
    out_t                 res;

    assign s_ready = (level <= OUT_LVL_W'(OUT_FIFO_ACCEPT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr_view[i] = header_reg[i];
        end
        if (pos_reg == 16'(HDR_LEN - 1)) begin
            hdr_view[HDR_LEN-1] = in_reg.data_byte;
        end
    end

    always_comb begin
        in_header = (pos_reg < 16'(HDR_LEN));
        pay_pos   = pos_reg - 16'(HDR_LEN);
        win_next  = in_header ? win_reg : {in_reg.data_byte, win_reg[23:8]};
        end_byte  = (17'(neb_reg) + 17'd15) >> 3;
        emit      = !in_header && !fin_reg && ant_ok_reg && (end_byte == 17'(pay_pos));
        off       = (neb_reg[2:0] == 3'd0) ? 5'd8 : {2'b00, neb_reg[2:0]};

        rx_inc  = {1'b0, rx_reg} + (ANT_W+1)'(1);
        tx_inc  = {1'b0, tx_reg} + (ANT_W+1)'(1);
        sub_inc = {1'b0, sub_reg} + (SC_W+1)'(1);

        neb_next = neb_reg;
        sub_next = sub_reg;
        tx_next  = tx_reg;
        rx_next  = rx_reg;
        fin_next = fin_reg;

        res             = '0;
        res.kind        = KIND_CSI;
        res.real_part   = 8'(win_next >> off);
        res.imag_part   = 8'(win_next >> (off + 5'd8));
        res.tx_antenna  = 2'(tx_reg);
        res.rx_antenna  = 2'(rx_reg);
        res.subcarrier  = 5'(sub_reg);
        res.last_of_run = 1'b1;

        if (emit) begin
            neb_next = neb_reg + 16'd16;
            rx_next  = ANT_W'(rx_inc);
            if (8'(rx_inc) >= hdr_view[HDR_NRX]) begin
                rx_next = '0;
                tx_next = ANT_W'(tx_inc);
                if (8'(tx_inc) >= hdr_view[HDR_NTX]) begin
                    tx_next  = '0;
                    sub_next = SC_W'(sub_inc);
                    neb_next = neb_reg + 16'd19;
                    if (sub_inc >= SC_COUNT) begin
                        fin_next        = 1'b1;
                        res.record_done = 1'b1;
                    end
                end
            end
        end

        calc_sum = 32'(NUM_SUBCARRIERS) * {12'd0, prod_reg, 4'b0011} + 32'd7;
        len      = {hdr_view[17], hdr_view[16]};
        len_ok   = ({16'd0, len} == (calc_sum >> 3));

        push = '0;
        if (in_valid_reg) begin
            if (pos_reg == 16'(HDR_LEN - 1)) begin
                push.count            = 2'd3;
                push.item[0]          = '0;
                push.item[0].kind     = KIND_TIMING;
                push.item[0].info     = {8'd0, hdr_view[5], hdr_view[4], hdr_view[3],
                                         hdr_view[2], hdr_view[1], hdr_view[0]};
                push.item[1]          = '0;
                push.item[1].kind     = KIND_RADIO;
                push.item[1].info     = {hdr_view[19], hdr_view[18], hdr_view[14],
                                         hdr_view[13], hdr_view[12], hdr_view[11],
                                         hdr_view[10]};
                push.item[2]          = '0;
                push.item[2].kind     = KIND_ANTENNA;
                push.item[2].info     = {16'd0, len, len_ok, ant_ok_reg,
                                         hdr_view[15][5:4], hdr_view[15][3:2],
                                         hdr_view[15][1:0], hdr_view[HDR_NTX],
                                         hdr_view[HDR_NRX]};
                push.item[2].last_of_run = 1'b1;
            end else if (emit) begin
                push.count   = 2'd1;
                push.item[0] = res;
            end
        end

        if (in_reg.end_of_record) begin
            pos_next = '0;
        end else if (pos_reg != 16'hFFFF) begin
            pos_next = pos_reg + 16'd1;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg) begin
            if (in_header) begin
                header_reg[5'(pos_reg)] <= in_reg.data_byte;
            end
            if (pos_reg == 16'(HDR_PROD)) begin
                prod_reg   <= 16'(header_reg[HDR_NRX]) * 16'(header_reg[HDR_NTX]);
                ant_ok_reg <= (header_reg[HDR_NRX] >= 8'd1) &&
                              (header_reg[HDR_NRX] <= ANT_MAX) &&
                              (header_reg[HDR_NTX] >= 8'd1) &&
                              (header_reg[HDR_NTX] <= ANT_MAX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            win_reg <= '0;
            neb_reg <= 16'd3;
            sub_reg <= '0;
            tx_reg  <= '0;
            rx_reg  <= '0;
            fin_reg <= 1'b0;
        end else if (in_valid_reg) begin
            pos_reg <= pos_next;
            if (in_reg.end_of_record) begin
                win_reg <= '0;
                neb_reg <= 16'd3;
                sub_reg <= '0;
                tx_reg  <= '0;
                rx_reg  <= '0;
                fin_reg <= 1'b0;
            end else begin
                win_reg <= win_next;
                neb_reg <= neb_next;
                sub_reg <= sub_next;
                tx_reg  <= tx_next;
                rx_reg  <= rx_next;
                fin_reg <= fin_next;
            end
        end
    end

    cfrp_result_fifo u_result_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .level   (level)
    );

endmodule
